@@ rtl/core/assert_macros.svh @@
// Assertion helpers used by the lexer unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/core/rll_pkg.sv @@
`default_nettype none

package rll_pkg;

	localparam int KW_COUNT = 17;

	typedef logic [KW_COUNT-1:0] kw_mask_t;

	localparam logic [4:0] TK_EOF     = 5'd0;
	localparam logic [4:0] TK_DOT     = 5'd1;
	localparam logic [4:0] TK_LPAREN  = 5'd2;
	localparam logic [4:0] TK_RPAREN  = 5'd3;
	localparam logic [4:0] TK_STRING  = 5'd4;
	localparam logic [4:0] TK_UUID    = 5'd5;
	localparam logic [4:0] TK_IDENT   = 5'd6;
	localparam logic [4:0] TK_KW_BASE = 5'd7;
	localparam logic [4:0] TK_TEXT    = 5'd24;
	localparam logic [4:0] TK_ERROR   = 5'd25;

	localparam logic [2:0] ERR_UNEXPECTED = 3'd0;
	localparam logic [2:0] ERR_UNTERM     = 3'd1;
	localparam logic [2:0] ERR_BAD_ESC    = 3'd2;
	localparam logic [2:0] ERR_DIGITS     = 3'd3;
	localparam logic [2:0] ERR_NOT_ENDED  = 3'd4;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_LOW_X  = 8'h78;

	// Keyword spellings, right aligned in 80 bits, first character highest.
	localparam logic [79:0] KW_TEXT [KW_COUNT] = '{
		"TEST", "TITLE", "WHEN", "THEN", "MESSAGE", "REFERENCE", "FAIL", "WARN",
		"INFO", "AND", "OR", "NOT", "EA", "HAS", "LACKS", "EQUALS", {"NOT_", "EQUALS"}
	};

	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd4, 4'd5, 4'd4, 4'd4, 4'd7, 4'd9, 4'd4, 4'd4,
		4'd4, 4'd3, 4'd2, 4'd3, 4'd2, 4'd3, 4'd5, 4'd6, 4'd10
	};

	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] line;
		logic [15:0] column;
		logic [7:0]  ch;
		logic [15:0] uuid;
		logic [2:0]  err;
		logic        last;
	} result_t;

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic is_word(input logic [7:0] b);
		return is_alpha(b) || is_digit(b) || b == CH_UNDER;
	endfunction

	function automatic logic is_hex(input logic [7:0] b);
		return is_digit(b) || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_nibble(input logic [7:0] b);
		return is_digit(b) ? b[3:0] : b[3:0] + 4'd9;
	endfunction

	// Keywords whose character at position pos equals b.
	function automatic kw_mask_t kw_match(input logic [7:0] b, input logic [3:0] pos);
		kw_mask_t m;
		logic [3:0] d;
		m = '0;
		for (int k = 0; k < KW_COUNT; k++) begin
			d = KW_LEN[k] - pos - 4'd1;
			if (pos < KW_LEN[k]) begin
				m[k] = (KW_TEXT[k][{d, 3'b000} +: 8] == b);
			end
		end
		return m;
	endfunction

	function automatic logic [4:0] kw_kind(input kw_mask_t mask, input logic [3:0] len);
		logic [4:0] kind;
		kind = TK_IDENT;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (mask[k] && KW_LEN[k] == len) begin
				kind = TK_KW_BASE + 5'(k);
			end
		end
		return kind;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/rule_language_lexer_unit.sv @@
// The first result of an input word is offered on the output once the word has passed the
// input register and been written into the output queue; it waits while the queue is full.
// Throughput: one input word per cycle while the output queue holds at most two results;
// a word that yields two results writes both into the queue together.
// A four-entry output queue lets input continue while results wait to be taken.
// Reset (arst_n low, asynchronous): queues empty, lexer idle, line and column at 1.
`default_nettype none

`include "assert_macros.svh"

module rule_language_lexer_unit #(
	parameter int LINE_WIDTH   = 16,
	parameter int COLUMN_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        src_valid,
	output logic             src_ready,
	input  wire logic [7:0]  in_byte,
	input  wire logic        end_of_input,
	output logic             tok_valid,
	input  wire logic        tok_ready,
	output logic [4:0]       token_kind,
	output logic [15:0]      token_line,
	output logic [15:0]      token_column,
	output logic [7:0]       text_char,
	output logic [15:0]      uuid_value,
	output logic [2:0]       error_code,
	output logic             last
);

	import rll_pkg::*;

	typedef enum logic [2:0] {
		M_IDLE, M_ZERO, M_HEX, M_IDENT, M_STR, M_ESC, M_ERR
	} mode_t;

	localparam logic [LINE_WIDTH-1:0]   LineOne = LINE_WIDTH'(1);
	localparam logic [COLUMN_WIDTH-1:0] ColOne  = COLUMN_WIDTH'(1);

	logic                    v_s1;
	logic [7:0]              byte_s1;
	logic                    eoi_s1;
	logic                    fire_s1;

	mode_t                   mode_q;
	logic [LINE_WIDTH-1:0]   line_q;
	logic [COLUMN_WIDTH-1:0] col_q;
	logic [LINE_WIDTH-1:0]   sline_q;
	logic [COLUMN_WIDTH-1:0] scol_q;
	logic [2:0]              hcnt_q;
	logic [15:0]             hacc_q;
	kw_mask_t                kmask_q;
	logic [3:0]              ipos_q;

	result_t                 fifo_q [4];
	logic [1:0]              wp_q;
	logic [1:0]              rp_q;
	logic [2:0]              cnt_q;
	logic                    pop;

	logic [LINE_WIDTH+15:0]   line_ext;
	logic [LINE_WIDTH+15:0]   sline_ext;
	logic [COLUMN_WIDTH+15:0] col_ext;
	logic [COLUMN_WIDTH+15:0] scol_ext;
	logic [15:0]              line16;
	logic [15:0]              col16;
	logic [15:0]              sline16;
	logic [15:0]              scol16;

	logic     idle_v;
	result_t  idle_r;
	mode_t    idle_mode;
	logic     idle_start;
	kw_mask_t idle_kmask;
	logic [3:0] idle_ipos;

	logic       pre_v;
	result_t    pre_r;
	logic       sec_v;
	result_t    sec_r;
	logic       run_idle;
	mode_t      n_mode;
	logic [2:0] n_hcnt;
	logic [15:0] n_hacc;
	kw_mask_t   n_kmask;
	logic [3:0] n_ipos;
	logic       n_start;
	result_t    r0;
	result_t    r1;
	logic [1:0] n_c;
	result_t    head;

	assign fire_s1   = v_s1 && (cnt_q <= 3'd2);
	assign src_ready = !v_s1 || fire_s1;
	assign tok_valid = cnt_q != 3'd0;
	assign pop       = tok_valid && tok_ready;

	assign line_ext  = {16'b0, line_q};
	assign sline_ext = {16'b0, sline_q};
	assign col_ext   = {16'b0, col_q};
	assign scol_ext  = {16'b0, scol_q};
	assign line16    = line_ext[15:0];
	assign sline16   = sline_ext[15:0];
	assign col16     = col_ext[15:0];
	assign scol16    = scol_ext[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (src_ready) begin
			v_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && src_ready) begin
			byte_s1 <= in_byte;
			eoi_s1  <= end_of_input;
		end
	end

	// A byte seen between tokens.
	always_comb begin
		idle_v        = 1'b0;
		idle_r        = '0;
		idle_r.line   = line16;
		idle_r.column = col16;
		idle_mode     = M_IDLE;
		idle_start    = 1'b0;
		idle_kmask    = kmask_q;
		idle_ipos     = ipos_q;
		if (byte_s1 == CH_SPACE || byte_s1 == CH_TAB || byte_s1 == CH_CR ||
				byte_s1 == CH_LF) begin
			idle_v = 1'b0;
		end else if (byte_s1 == CH_DOT) begin
			idle_v      = 1'b1;
			idle_r.kind = TK_DOT;
		end else if (byte_s1 == CH_LPAR) begin
			idle_v      = 1'b1;
			idle_r.kind = TK_LPAREN;
		end else if (byte_s1 == CH_RPAR) begin
			idle_v      = 1'b1;
			idle_r.kind = TK_RPAREN;
		end else begin
			idle_start = 1'b1;
			if (byte_s1 == CH_QUOTE) begin
				idle_mode = M_STR;
			end else if (byte_s1 == CH_ZERO) begin
				idle_mode = M_ZERO;
			end else if (is_alpha(byte_s1) || byte_s1 == CH_UNDER) begin
				idle_mode   = M_IDENT;
				idle_kmask  = kw_match(byte_s1, 4'd0);
				idle_ipos   = 4'd1;
				idle_v      = 1'b1;
				idle_r.kind = TK_TEXT;
				idle_r.ch   = byte_s1;
			end else begin
				idle_mode   = M_ERR;
				idle_v      = 1'b1;
				idle_r.kind = TK_ERROR;
				idle_r.err  = ERR_UNEXPECTED;
			end
		end
	end

	always_comb begin
		pre_v        = 1'b0;
		pre_r        = '0;
		pre_r.line   = sline16;
		pre_r.column = scol16;
		run_idle     = 1'b0;
		n_mode       = mode_q;
		n_hcnt       = hcnt_q;
		n_hacc       = hacc_q;
		n_kmask      = kmask_q;
		n_ipos       = ipos_q;
		n_start      = 1'b0;
		sec_v        = 1'b0;
		sec_r        = idle_r;
		if (eoi_s1) begin
			case (mode_q)
				M_IDENT: begin
					pre_v      = 1'b1;
					pre_r.kind = kw_kind(kmask_q, ipos_q);
				end
				M_STR, M_ESC: begin
					pre_v      = 1'b1;
					pre_r.kind = TK_ERROR;
					pre_r.err  = ERR_UNTERM;
				end
				M_ZERO: begin
					pre_v      = 1'b1;
					pre_r.kind = TK_ERROR;
					pre_r.err  = ERR_UNEXPECTED;
				end
				M_HEX: begin
					pre_v = 1'b1;
					if (hcnt_q == 3'd4) begin
						pre_r.kind = TK_UUID;
						pre_r.uuid = hacc_q;
					end else begin
						pre_r.kind = TK_ERROR;
						pre_r.err  = ERR_DIGITS;
					end
				end
				default: begin
					pre_v = 1'b0;
				end
			endcase
			sec_v        = 1'b1;
			sec_r        = '0;
			sec_r.kind   = TK_EOF;
			sec_r.line   = line16;
			sec_r.column = col16;
		end else begin
			case (mode_q)
				M_IDENT: begin
					pre_v = 1'b1;
					if (is_word(byte_s1)) begin
						pre_r.kind = TK_TEXT;
						pre_r.ch   = byte_s1;
						n_kmask    = kmask_q & kw_match(byte_s1, ipos_q);
						if (ipos_q != 4'd15) begin
							n_ipos = ipos_q + 4'd1;
						end
					end else begin
						pre_r.kind = kw_kind(kmask_q, ipos_q);
						run_idle   = 1'b1;
					end
				end
				M_STR: begin
					if (byte_s1 == CH_QUOTE) begin
						pre_v      = 1'b1;
						pre_r.kind = TK_STRING;
						n_mode     = M_IDLE;
					end else if (byte_s1 == CH_BSLASH) begin
						n_mode = M_ESC;
					end else if (byte_s1 == CH_LF) begin
						pre_v      = 1'b1;
						pre_r.kind = TK_ERROR;
						pre_r.err  = ERR_UNTERM;
						n_mode     = M_ERR;
					end else begin
						pre_v      = 1'b1;
						pre_r.kind = TK_TEXT;
						pre_r.ch   = byte_s1;
					end
				end
				M_ESC: begin
					pre_v  = 1'b1;
					n_mode = M_STR;
					pre_r.kind = TK_TEXT;
					if (byte_s1 == CH_QUOTE || byte_s1 == CH_BSLASH) begin
						pre_r.ch = byte_s1;
					end else if (byte_s1 == CH_LOW_N) begin
						pre_r.ch = CH_LF;
					end else if (byte_s1 == CH_LOW_T) begin
						pre_r.ch = CH_TAB;
					end else begin
						pre_r.kind = TK_ERROR;
						pre_r.err  = ERR_BAD_ESC;
						n_mode     = M_ERR;
					end
				end
				M_ZERO: begin
					if (byte_s1 == CH_LOW_X) begin
						n_mode = M_HEX;
						n_hcnt = 3'd0;
						n_hacc = 16'd0;
					end else begin
						pre_v      = 1'b1;
						pre_r.kind = TK_ERROR;
						pre_r.err  = ERR_UNEXPECTED;
						n_mode     = M_ERR;
					end
				end
				M_HEX: begin
					if (is_hex(byte_s1)) begin
						if (hcnt_q < 3'd5) begin
							n_hcnt = hcnt_q + 3'd1;
						end
						n_hacc = {hacc_q[11:0], hex_nibble(byte_s1)};
					end else if (hcnt_q != 3'd4) begin
						pre_v      = 1'b1;
						pre_r.kind = TK_ERROR;
						pre_r.err  = ERR_DIGITS;
						n_mode     = M_ERR;
					end else if (is_word(byte_s1)) begin
						pre_v      = 1'b1;
						pre_r.kind = TK_ERROR;
						pre_r.err  = ERR_NOT_ENDED;
						n_mode     = M_ERR;
					end else begin
						pre_v      = 1'b1;
						pre_r.kind = TK_UUID;
						pre_r.uuid = hacc_q;
						run_idle   = 1'b1;
					end
				end
				M_ERR: begin
					n_mode = M_ERR;
				end
				default: begin
					run_idle = 1'b1;
				end
			endcase
			if (run_idle) begin
				n_mode  = idle_mode;
				n_start = idle_start;
				n_kmask = idle_kmask;
				n_ipos  = idle_ipos;
				sec_v   = idle_v;
			end
		end
	end

	always_comb begin
		if (pre_v) begin
			r0  = pre_r;
			r1  = sec_r;
			n_c = sec_v ? 2'd2 : 2'd1;
		end else begin
			r0  = sec_r;
			r1  = '0;
			n_c = sec_v ? 2'd1 : 2'd0;
		end
		if (n_c == 2'd2) begin
			r1.last = 1'b1;
		end else if (n_c == 2'd1) begin
			r0.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			line_q  <= LineOne;
			col_q   <= ColOne;
			sline_q <= LineOne;
			scol_q  <= ColOne;
			hcnt_q  <= 3'd0;
			hacc_q  <= 16'd0;
			kmask_q <= '1;
			ipos_q  <= 4'd0;
		end else if (fire_s1) begin
			if (eoi_s1) begin
				mode_q  <= M_IDLE;
				line_q  <= LineOne;
				col_q   <= ColOne;
				sline_q <= LineOne;
				scol_q  <= ColOne;
				hcnt_q  <= 3'd0;
				hacc_q  <= 16'd0;
				kmask_q <= '1;
				ipos_q  <= 4'd0;
			end else begin
				mode_q  <= n_mode;
				hcnt_q  <= n_hcnt;
				hacc_q  <= n_hacc;
				kmask_q <= n_kmask;
				ipos_q  <= n_ipos;
				if (n_start) begin
					sline_q <= line_q;
					scol_q  <= col_q;
				end
				if (byte_s1 == CH_LF) begin
					if (!(&line_q)) begin
						line_q <= line_q + LineOne;
					end
					col_q <= ColOne;
				end else if (!(&col_q)) begin
					col_q <= col_q + ColOne;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			if (n_c != 2'd0) begin
				fifo_q[wp_q] <= r0;
			end
			if (n_c == 2'd2) begin
				fifo_q[wp_q + 2'd1] <= r1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 2'd0;
			rp_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (fire_s1) begin
				wp_q <= wp_q + n_c;
			end
			if (pop) begin
				rp_q <= rp_q + 2'd1;
			end
			cnt_q <= cnt_q + (fire_s1 ? {1'b0, n_c} : 3'd0) - {2'b0, pop};
		end
	end

	assign head         = fifo_q[rp_q];
	assign token_kind   = head.kind;
	assign token_line   = head.line;
	assign token_column = head.column;
	assign text_char    = head.ch;
	assign uuid_value   = head.uuid;
	assign error_code   = head.err;
	assign last         = head.last;

	`ASSERT_NEVER(a_queue_bound, clk, arst_n, cnt_q > 3'd4, "output queue overflow")
	`ASSERT_AT(a_eoi_emits, clk, arst_n, (fire_s1 && eoi_s1) |-> (n_c != 2'd0), "end word without result")
	`ASSERT_AT(a_eoi_resets, clk, arst_n, (fire_s1 && eoi_s1) |=> (mode_q == M_IDLE && ipos_q == 4'd0 && hcnt_q == 3'd0), "state not cleared after end word")
	`ASSERT_AT(a_err_silent, clk, arst_n, (fire_s1 && !eoi_s1 && mode_q == M_ERR) |-> (n_c == 2'd0), "result emitted while skipping after an error")

endmodule

`default_nettype wire

@@ tb/tb_rule_language_lexer_unit.sv @@
`timescale 1ns / 100ps

module tb_rule_language_lexer_unit;
	import rll_pkg::*;

	localparam int WATCHDOG_CYCLES = 400_000;
	localparam int RANDOM_WORDS = 1000;
	localparam int QUIET_TAIL = 250;
	localparam logic [15:0] POS_MAX = 16'hFFFF;
	localparam logic [2:0] NO_ERROR = 3'd0;

	typedef enum logic [2:0] {
		SCAN_IDLE, SCAN_ZERO, SCAN_HEX, SCAN_IDENT, SCAN_STRING, SCAN_ESCAPE, SCAN_FAILED
	} scan_mode_e;

	logic clk, arst_n;
	logic src_valid, src_ready, end_of_input;
	logic [7:0] in_byte;
	logic tok_valid, tok_ready;
	logic [4:0] token_kind;
	logic [15:0] token_line, token_column, uuid_value;
	logic [7:0] text_char;
	logic [2:0] error_code;
	logic last;

	rule_language_lexer_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.in_byte(in_byte),
		.end_of_input(end_of_input),
		.tok_valid(tok_valid),
		.tok_ready(tok_ready),
		.token_kind(token_kind),
		.token_line(token_line),
		.token_column(token_column),
		.text_char(text_char),
		.uuid_value(uuid_value),
		.error_code(error_code),
		.last(last)
	);

	string kw_spelling [KW_COUNT] = '{
		"TEST", "TITLE", "WHEN", "THEN", "MESSAGE", "REFERENCE", "FAIL", "WARN",
		"INFO", "AND", "OR", "NOT", "EA", "HAS", "LACKS", "EQUALS",
		string'({"NOT_", "EQUALS"})
	};

	scan_mode_e scan_mode;
	logic [15:0] cur_line, cur_col, tok_line, tok_col, hex_value;
	logic [2:0] hex_digits;
	kw_mask_t kw_candidates;
	logic [3:0] ident_len;
	result_t step_tokens [$];
	result_t expected_tokens [$];

	bit src_idle_en, sink_idle_en;
	int hold_request;
	int words_sent, tokens_checked, mismatches, cycle_count;
	bit kind_seen [32];
	bit code_seen [8];

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
	endfunction

	function automatic logic is_decimal(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic is_name_char(input logic [7:0] b);
		return is_letter(b) || is_decimal(b) || b == CH_UNDER;
	endfunction

	function automatic int hex_digit_value(input logic [7:0] b);
		if (is_decimal(b)) return b - "0";
		if (b >= "a" && b <= "f") return b - "a" + 10;
		if (b >= "A" && b <= "F") return b - "A" + 10;
		return -1;
	endfunction

	function automatic void scan_reset();
		scan_mode = SCAN_IDLE;
		cur_line = 16'd1;
		cur_col = 16'd1;
		tok_line = 16'd1;
		tok_col = 16'd1;
		hex_digits = 3'd0;
		hex_value = 16'd0;
		kw_candidates = '1;
		ident_len = 4'd0;
	endfunction

	function automatic void add_token(input logic [4:0] kind, input logic [15:0] ln,
			input logic [15:0] cl, input logic [7:0] ch, input logic [15:0] val,
			input logic [2:0] code);
		result_t r;
		r.kind = kind;
		r.line = ln;
		r.column = cl;
		r.ch = ch;
		r.uuid = val;
		r.err = code;
		r.last = 1'b0;
		if (step_tokens.size() < 2) step_tokens.insert(step_tokens.size(), r);
	endfunction

	function automatic void take_ident_char(input logic [7:0] b);
		for (int k = 0; k < KW_COUNT; k++) begin
			if (ident_len >= kw_spelling[k].len() || kw_spelling[k][ident_len] != b) begin
				kw_candidates[k] = 1'b0;
			end
		end
		if (ident_len < 4'd15) ident_len++;
		add_token(TK_TEXT, tok_line, tok_col, b, 16'd0, NO_ERROR);
	endfunction

	function automatic void close_ident();
		logic [4:0] kind;
		kind = TK_IDENT;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (kw_candidates[k] && kw_spelling[k].len() == ident_len) kind = TK_KW_BASE + 5'(k);
		end
		add_token(kind, tok_line, tok_col, 8'd0, 16'd0, NO_ERROR);
		scan_mode = SCAN_IDLE;
	endfunction

	function automatic void scan_idle_byte(input logic [7:0] b, input logic [15:0] ln,
			input logic [15:0] cl);
		scan_mode = SCAN_IDLE;
		if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) return;
		if (b == CH_DOT) begin
			add_token(TK_DOT, ln, cl, 8'd0, 16'd0, NO_ERROR);
			return;
		end
		if (b == CH_LPAR) begin
			add_token(TK_LPAREN, ln, cl, 8'd0, 16'd0, NO_ERROR);
			return;
		end
		if (b == CH_RPAR) begin
			add_token(TK_RPAREN, ln, cl, 8'd0, 16'd0, NO_ERROR);
			return;
		end
		tok_line = ln;
		tok_col = cl;
		if (b == CH_QUOTE) begin
			scan_mode = SCAN_STRING;
			return;
		end
		if (b == CH_ZERO) begin
			scan_mode = SCAN_ZERO;
			return;
		end
		if (is_letter(b) || b == CH_UNDER) begin
			scan_mode = SCAN_IDENT;
			kw_candidates = '1;
			ident_len = 4'd0;
			take_ident_char(b);
			return;
		end
		add_token(TK_ERROR, ln, cl, 8'd0, 16'd0, ERR_UNEXPECTED);
		scan_mode = SCAN_FAILED;
	endfunction

	function automatic void scan_word(input logic [7:0] b, input logic eoi);
		logic [15:0] ln, cl;
		logic [7:0] c;
		int v;
		result_t r;
		ln = cur_line;
		cl = cur_col;
		step_tokens.delete();
		if (eoi) begin
			case (scan_mode)
				SCAN_IDENT: close_ident();
				SCAN_STRING, SCAN_ESCAPE: add_token(TK_ERROR, tok_line, tok_col, 8'd0, 16'd0, ERR_UNTERM);
				SCAN_ZERO: add_token(TK_ERROR, tok_line, tok_col, 8'd0, 16'd0, ERR_UNEXPECTED);
				SCAN_HEX: begin
					if (hex_digits == 3'd4) add_token(TK_UUID, tok_line, tok_col, 8'd0, hex_value, NO_ERROR);
					else add_token(TK_ERROR, tok_line, tok_col, 8'd0, 16'd0, ERR_DIGITS);
				end
				default: ;
			endcase
			add_token(TK_EOF, ln, cl, 8'd0, 16'd0, NO_ERROR);
			scan_reset();
		end else begin
			case (scan_mode)
				SCAN_IDENT: begin
					if (is_name_char(b)) take_ident_char(b);
					else begin
						close_ident();
						scan_idle_byte(b, ln, cl);
					end
				end
				SCAN_STRING: begin
					if (b == CH_QUOTE) begin
						add_token(TK_STRING, tok_line, tok_col, 8'd0, 16'd0, NO_ERROR);
						scan_mode = SCAN_IDLE;
					end else if (b == CH_BSLASH) begin
						scan_mode = SCAN_ESCAPE;
					end else if (b == CH_LF) begin
						add_token(TK_ERROR, tok_line, tok_col, 8'd0, 16'd0, ERR_UNTERM);
						scan_mode = SCAN_FAILED;
					end else begin
						add_token(TK_TEXT, tok_line, tok_col, b, 16'd0, NO_ERROR);
					end
				end
				SCAN_ESCAPE: begin
					if (b == CH_QUOTE || b == CH_BSLASH || b == CH_LOW_N || b == CH_LOW_T) begin
						c = (b == CH_LOW_N) ? CH_LF : (b == CH_LOW_T) ? CH_TAB : b;
						add_token(TK_TEXT, tok_line, tok_col, c, 16'd0, NO_ERROR);
						scan_mode = SCAN_STRING;
					end else begin
						add_token(TK_ERROR, tok_line, tok_col, 8'd0, 16'd0, ERR_BAD_ESC);
						scan_mode = SCAN_FAILED;
					end
				end
				SCAN_ZERO: begin
					if (b == CH_LOW_X) begin
						scan_mode = SCAN_HEX;
						hex_digits = 3'd0;
						hex_value = 16'd0;
					end else begin
						add_token(TK_ERROR, tok_line, tok_col, 8'd0, 16'd0, ERR_UNEXPECTED);
						scan_mode = SCAN_FAILED;
					end
				end
				SCAN_HEX: begin
					v = hex_digit_value(b);
					if (v >= 0) begin
						if (hex_digits < 3'd5) hex_digits++;
						hex_value = {hex_value[11:0], v[3:0]};
					end else if (hex_digits != 3'd4) begin
						add_token(TK_ERROR, tok_line, tok_col, 8'd0, 16'd0, ERR_DIGITS);
						scan_mode = SCAN_FAILED;
					end else if (is_name_char(b)) begin
						add_token(TK_ERROR, tok_line, tok_col, 8'd0, 16'd0, ERR_NOT_ENDED);
						scan_mode = SCAN_FAILED;
					end else begin
						add_token(TK_UUID, tok_line, tok_col, 8'd0, hex_value, NO_ERROR);
						scan_idle_byte(b, ln, cl);
					end
				end
				SCAN_FAILED: ;
				default: scan_idle_byte(b, ln, cl);
			endcase
			if (b == CH_LF) begin
				if (cur_line != POS_MAX) cur_line++;
				cur_col = 16'd1;
			end else if (cur_col != POS_MAX) begin
				cur_col++;
			end
		end
		if (step_tokens.size() > 0) begin
			r = step_tokens.pop_back();
			r.last = 1'b1;
			step_tokens.insert(step_tokens.size(), r);
		end
		foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count <= WATCHDOG_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Watchdog expired with %0d result words still expected.",
			expected_tokens.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	// The sink stalls in random bursts while sink_idle_en is set and honors one long hold-off on request.
	initial begin
		int stall_left;
		tok_ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end else if (stall_left == 0 && sink_idle_en && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 17);
			end
			if (stall_left > 0) begin
				tok_ready = 1'b0;
				stall_left--;
			end else begin
				tok_ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && tok_valid && tok_ready) begin
			got.kind = token_kind;
			got.line = token_line;
			got.column = token_column;
			got.ch = text_char;
			got.uuid = uuid_value;
			got.err = error_code;
			got.last = last;
			if (expected_tokens.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Unexpected result word: kind %0d line %0d column %0d.",
						got.kind, got.line, got.column);
				end
			end else begin
				want = expected_tokens.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Mismatch on result word %0d:", tokens_checked);
						$display("  expected kind %0d line %0d col %0d char %02h uuid %04h err %0d last %0d",
							want.kind, want.line, want.column, want.ch, want.uuid, want.err, want.last);
						$display("  actual   kind %0d line %0d col %0d char %02h uuid %04h err %0d last %0d",
							got.kind, got.line, got.column, got.ch, got.uuid, got.err, got.last);
					end
				end else begin
					kind_seen[got.kind] = 1'b1;
					if (got.kind == TK_ERROR) code_seen[got.err] = 1'b1;
				end
				tokens_checked++;
			end
		end
	end

	task automatic send_word(input logic [7:0] b, input logic eoi);
		int gap;
		@(negedge clk);
		if (src_idle_en && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 17);
			src_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		src_valid = 1'b1;
		in_byte = b;
		end_of_input = eoi;
		do @(posedge clk); while (!src_ready);
		scan_word(b, eoi);
		words_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
	endtask

	task automatic send_eof();
		send_word(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic pause_until_drained();
		@(negedge clk);
		src_valid = 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] random_name_char(input bit leading);
		int r;
		r = $urandom_range(0, leading ? 52 : 62);
		if (r < 26) return 8'("A" + r);
		if (r < 52) return 8'("a" + r - 26);
		if (r == 52) return CH_UNDER;
		return 8'("0" + r - 53);
	endfunction

	task automatic send_random_string();
		int n, pick;
		logic [7:0] c;
		send_word(CH_QUOTE, 1'b0);
		n = $urandom_range(0, 8);
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 14) begin
				send_word(CH_BSLASH, 1'b0);
				case ($urandom_range(0, 3))
					0: c = CH_QUOTE;
					1: c = CH_BSLASH;
					2: c = CH_LOW_N;
					default: c = CH_LOW_T;
				endcase
				send_word(c, 1'b0);
			end else if (pick < 16) begin
				send_word(CH_BSLASH, 1'b0);
				do c = 8'($urandom_range(0, 255));
				while (c == CH_QUOTE || c == CH_BSLASH || c == CH_LOW_N || c == CH_LOW_T);
				send_word(c, 1'b0);
			end else if (pick < 18) begin
				send_word(CH_LF, 1'b0);
			end else if (pick < 24) begin
				send_word(8'($urandom_range(128, 255)), 1'b0);
			end else begin
				do c = 8'($urandom_range(32, 126)); while (c == CH_QUOTE || c == CH_BSLASH);
				send_word(c, 1'b0);
			end
		end
		if ($urandom_range(0, 11) != 0) send_word(CH_QUOTE, 1'b0);
	endtask

	task automatic send_random_uuid();
		string hex_chars;
		int digits;
		hex_chars = "0123456789abcdefABCDEF";
		send_word(CH_ZERO, 1'b0);
		if ($urandom_range(0, 19) == 0) return;
		send_word(CH_LOW_X, 1'b0);
		digits = ($urandom_range(0, 4) != 0) ? 4 : $urandom_range(0, 6);
		repeat (digits) send_word(hex_chars[$urandom_range(0, 21)], 1'b0);
		if ($urandom_range(0, 9) == 0) send_word(random_name_char(1'b0), 1'b0);
		else if ($urandom_range(0, 1) != 0) send_word(CH_SPACE, 1'b0);
	endtask

	task automatic send_random_fragment();
		int pick, n;
		string s;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			s = kw_spelling[$urandom_range(0, KW_COUNT - 1)];
			case ($urandom_range(0, 9))
				0: s = {s, "_"};
				1: s = s.substr(0, s.len() - 2);
				default: ;
			endcase
			send_text(s);
			if ($urandom_range(0, 2) != 0) send_word(CH_SPACE, 1'b0);
		end else if (pick < 32) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
			send_word(random_name_char(1'b1), 1'b0);
			repeat (n - 1) send_word(random_name_char(1'b0), 1'b0);
		end else if (pick < 47) begin
			send_random_string();
		end else if (pick < 60) begin
			send_random_uuid();
		end else if (pick < 72) begin
			case ($urandom_range(0, 2))
				0: send_word(CH_DOT, 1'b0);
				1: send_word(CH_LPAR, 1'b0);
				default: send_word(CH_RPAR, 1'b0);
			endcase
		end else if (pick < 88) begin
			case ($urandom_range(0, 3))
				0: send_word(CH_SPACE, 1'b0);
				1: send_word(CH_TAB, 1'b0);
				2: send_word(CH_CR, 1'b0);
				default: send_word(CH_LF, 1'b0);
			endcase
		end else if (pick < 95) begin
			send_word(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			send_eof();
		end
	endtask

	task automatic test_punctuation_and_keywords();
		send_text(".()0xBEEF) TEST\nNOT_");
		send_text("EQUALS(x");
		send_eof();
		pause_until_drained();
	endtask

	task automatic test_string_escapes();
		send_text("\"a\\\"\\\\\\n\\t\" ");
		send_text("\"ab\nc");
		send_eof();
		send_text("\"\\");
		send_eof();
		send_text("\"x\\q.");
		send_eof();
		send_text("\"open");
		send_eof();
		pause_until_drained();
	endtask

	task automatic test_hex_literals();
		send_text("0y");
		send_eof();
		send_text("0");
		send_eof();
		send_text("0x12)");
		send_eof();
		send_text("0x12345 ");
		send_eof();
		send_text("0xABCDg");
		send_eof();
		send_text("0x0000 0xffff");
		send_eof();
		pause_until_drained();
	endtask

	task automatic test_bad_bytes_and_long_names();
		send_word(8'hFF, 1'b0);
		send_word(8'h00, 1'b0);
		send_text("abc");
		send_eof();
		send_word(8'h00, 1'b0);
		send_eof();
		send_text("ABCDEFGHIJKLMNOPQRS NOT_");
		send_text("EQUALSX");
		send_eof();
		pause_until_drained();
	endtask

	task automatic test_position_limits();
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		repeat (40) send_word(CH_SPACE, 1'b0);
		send_word(CH_DOT, 1'b0);
		send_eof();
		repeat (25) send_word(CH_LF, 1'b0);
		send_text("(x");
		send_eof();
		pause_until_drained();
	endtask

	task automatic test_backpressure();
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		hold_request = 250;
		repeat (12) send_text("0x1234.(");
		send_eof();
		pause_until_drained();
	endtask

	task automatic test_random_text();
		int start, done;
		start = words_sent;
		done = 0;
		while (done < RANDOM_WORDS) begin
			if (done > RANDOM_WORDS - QUIET_TAIL) begin
				src_idle_en = 1'b0;
				sink_idle_en = 1'b0;
			end else begin
				src_idle_en = ((done / 150) % 3) != 2;
				sink_idle_en = ((done / 110) % 3) != 1;
			end
			send_random_fragment();
			done = words_sent - start;
		end
		send_eof();
		pause_until_drained();
	endtask

	initial begin
		int kinds, codes;
		arst_n = 1'b0;
		src_valid = 1'b0;
		in_byte = 8'd0;
		end_of_input = 1'b0;
		hold_request = 0;
		scan_reset();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;
		test_punctuation_and_keywords();
		test_string_escapes();
		test_hex_literals();
		test_bad_bytes_and_long_names();
		test_backpressure();
		test_position_limits();
		test_random_text();
		repeat (10) @(posedge clk);
		kinds = 0;
		codes = 0;
		foreach (kind_seen[i]) kinds += kind_seen[i];
		foreach (code_seen[i]) codes += code_seen[i];
		$display("Sent %0d source words and checked %0d result words, %0d mismatching.",
			words_sent, tokens_checked, mismatches);
		$display("Seen %0d of 26 token kinds and %0d of 5 error codes over directed and random text.",
			kinds, codes);
		if (expected_tokens.size() != 0) begin
			$display("%0d expected result words never arrived.", expected_tokens.size());
		end
		if (mismatches == 0 && expected_tokens.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
